[design/qlf_pkg.sv]
// Shared widths, request codes and QPACK prefix constants for the
// literal field line encoder. No dependencies.
package qlf_pkg;

  localparam int unsigned LEN_BITS_DEF = 16;
  localparam int unsigned REQ_W        = 2;
  localparam int unsigned LEN_IN_W     = 16;
  localparam int unsigned ROOM_W       = 20;
  localparam int unsigned BYTE_W       = 8;

  // request codes
  localparam logic [REQ_W-1:0] REQ_START = 2'd0;
  localparam logic [REQ_W-1:0] REQ_NAME  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_VALUE = 2'd2;

  // literal-with-literal-name pattern (top three bits of the first byte)
  localparam logic [2:0]        LIT_NAME_PAT = 3'b001;
  // all-ones prefixes: 3-bit for the name length, 7-bit for the value length
  localparam logic [BYTE_W-1:0] NAME_PFX_MAX = 8'h07;
  localparam logic [BYTE_W-1:0] VAL_PFX_MAX  = 8'h7F;
  localparam logic [BYTE_W-1:0] CONT_BIT     = 8'h80;
  localparam logic [BYTE_W-1:0] GRP_LIMIT    = 8'd128;
  localparam int unsigned       GRP_BITS     = 7;

endpackage

[design/qlf_if.sv]
// Valid/ready channel interfaces: request beats, result beats and the
// configuration write channel. Depends on qlf_pkg.
interface qlf_in_if;
  import qlf_pkg::*;
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [LEN_IN_W-1:0] name_length;
  logic [LEN_IN_W-1:0] value_length;
  logic [ROOM_W-1:0]   room;
  logic [BYTE_W-1:0]   data_byte;
  modport source (output valid, req_type, name_length, value_length, room, data_byte,
                  input ready);
  modport sink   (input valid, req_type, name_length, value_length, room, data_byte,
                  output ready);
endinterface

interface qlf_out_if;
  import qlf_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              run_last;
  logic              header_done;
  logic              overflow;
  modport source (output valid, out_byte, run_last, header_done, overflow, input ready);
  modport sink   (input valid, out_byte, run_last, header_done, overflow, output ready);
endinterface

interface qlf_cfg_if;
  logic valid;
  logic ready;
  logic never_indexed;
  modport source (output valid, never_indexed, input ready);
  modport sink   (input valid, never_indexed, output ready);
endinterface

[design/qpack_literal_field_line_encoder.sv]
// QPACK literal field line encoder (literal name form).
// Name/value byte beats: one output byte each. Start beat: accept, size check,
// then one step per prefix-integer byte (1..4 at LEN_BITS 16); the last name
// byte also runs the value length prefix (1..4 bytes). One shared shift/subtract
// prefix unit emits one byte per cycle; output register stalls hold it.
// Reset (rst_n, sync, active low): idle, no header open, never_indexed = 1.
module qpack_literal_field_line_encoder #(
  parameter int unsigned LEN_BITS = qlf_pkg::LEN_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  qlf_in_if.sink   in_ch,
  qlf_out_if.source out_ch,
  qlf_cfg_if.sink  cfg_ch
);
  import qlf_pkg::*;

  // width of the size sum, wide enough for the room too
  localparam int unsigned CW = ((LEN_BITS + 2) > ROOM_W) ? (LEN_BITS + 3) : (ROOM_W + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_EMIT} state_t;
  typedef enum logic [1:0] {PH_IDLE, PH_NAME, PH_VALUE} phase_t;

  // encoded size of a prefix integer: parallel group compares, no loop chain
  function automatic logic [2:0] int_size(input logic [LEN_BITS-1:0] v,
                                          input logic [BYTE_W-1:0] top);
    logic [LEN_BITS-1:0] rest;
    logic [2:0]          n;
    rest = '0;
    if (v < LEN_BITS'(top)) begin
      n = 3'd1;
    end else begin
      rest = v - LEN_BITS'(top);
      n    = 3'd2;
      for (int k = 1; k <= 4; k++) begin
        if ((rest >> (GRP_BITS * k)) != '0) n = n + 3'd1;
      end
    end
    return n;
  endfunction

  state_t              state_r, state_nxt;
  phase_t              phase_r, phase_nxt;
  logic [LEN_BITS-1:0] bytes_left_r, bytes_left_nxt;
  logic [LEN_BITS-1:0] nl_r, nl_nxt;          // name length of open header
  logic [LEN_BITS-1:0] vl_r, vl_nxt;          // value length, held through name phase
  logic [ROOM_W-1:0]   room_r, room_nxt;
  logic                never_idx_r, never_idx_nxt;

  // shared prefix-integer unit
  logic [LEN_BITS-1:0] int_v_r, int_v_nxt;    // remainder still to emit
  logic                int_first_r, int_first_nxt;
  logic                int_is_val_r, int_is_val_nxt;
  logic [BYTE_W-1:0]   int_lead_r, int_lead_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_done_r, out_done_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic                slot;
  logic                in_fire;
  logic [LEN_BITS-1:0] bl_dec;
  logic [CW-1:0]       total;
  logic [LEN_BITS-1:0] top;
  logic [BYTE_W-1:0]   pfx_byte;
  logic                pfx_fin;

  assign slot    = !out_valid_r || out_ch.ready;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign bl_dec  = bytes_left_r - LEN_BITS'(1);

  assign in_ch.ready        = (state_r == ST_IDLE) && slot;
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.run_last    = out_last_r;
  assign out_ch.header_done = out_done_r;
  assign out_ch.overflow    = out_ovf_r;

  // whole line size against the room
  assign total = CW'(int_size(nl_r, NAME_PFX_MAX)) + CW'(nl_r)
               + CW'(int_size(vl_r, VAL_PFX_MAX)) + CW'(vl_r);

  // one prefix-integer byte per step: first byte, then 7-bit groups LS first
  assign top = int_is_val_r ? LEN_BITS'(VAL_PFX_MAX) : LEN_BITS'(NAME_PFX_MAX);
  always_comb begin
    pfx_byte  = '0;
    pfx_fin   = 1'b0;
    int_v_nxt = int_v_r;
    if (int_first_r) begin
      if (int_v_r < top) begin
        pfx_byte = int_lead_r | {1'b0, int_v_r[GRP_BITS-1:0]};
        pfx_fin  = 1'b1;
      end else begin
        pfx_byte  = int_lead_r | BYTE_W'(top);
        int_v_nxt = int_v_r - top;
      end
    end else if (int_v_r >= LEN_BITS'(GRP_LIMIT)) begin
      pfx_byte  = CONT_BIT | {1'b0, int_v_r[GRP_BITS-1:0]};
      int_v_nxt = int_v_r >> GRP_BITS;
    end else begin
      pfx_byte = {1'b0, int_v_r[GRP_BITS-1:0]};
      pfx_fin  = 1'b1;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    nl_nxt         = nl_r;
    vl_nxt         = vl_r;
    room_nxt       = room_r;
    never_idx_nxt  = never_idx_r;
    int_first_nxt  = int_first_r;
    int_is_val_nxt = int_is_val_r;
    int_lead_nxt   = int_lead_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_done_nxt   = out_done_r;
    out_ovf_nxt    = out_ovf_r;

    if (cfg_ch.valid) never_idx_nxt = cfg_ch.never_indexed;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_ch.req_type)
            REQ_START: begin
              // a start mid-header simply drops the open one
              nl_nxt    = LEN_BITS'(in_ch.name_length);
              vl_nxt    = LEN_BITS'(in_ch.value_length);
              room_nxt  = in_ch.room;
              phase_nxt = PH_IDLE;
              state_nxt = ST_CHECK;
            end
            REQ_NAME: begin
              if (phase_r == PH_NAME) begin
                out_valid_nxt  = 1'b1;
                out_byte_nxt   = in_ch.data_byte;
                out_done_nxt   = 1'b0;
                out_ovf_nxt    = 1'b0;
                out_last_nxt   = 1'b1;
                bytes_left_nxt = bl_dec;
                if (bl_dec == '0) begin
                  // name complete: value length prefix follows
                  out_last_nxt   = 1'b0;
                  phase_nxt      = PH_IDLE;
                  int_first_nxt  = 1'b1;
                  int_is_val_nxt = 1'b1;
                  int_lead_nxt   = '0;
                  state_nxt      = ST_EMIT;
                end
              end
            end
            REQ_VALUE: begin
              if (phase_r == PH_VALUE) begin
                out_valid_nxt  = 1'b1;
                out_byte_nxt   = in_ch.data_byte;
                out_last_nxt   = 1'b1;
                out_ovf_nxt    = 1'b0;
                out_done_nxt   = (bl_dec == '0);
                bytes_left_nxt = bl_dec;
                if (bl_dec == '0) phase_nxt = PH_IDLE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_CHECK: begin
        if (total > CW'(room_r)) begin
          if (slot) begin
            out_valid_nxt  = 1'b1;
            out_byte_nxt   = '0;
            out_last_nxt   = 1'b1;
            out_done_nxt   = 1'b1;
            out_ovf_nxt    = 1'b1;
            bytes_left_nxt = '0;
            state_nxt      = ST_IDLE;
          end
        end else begin
          int_first_nxt  = 1'b1;
          int_is_val_nxt = 1'b0;
          int_lead_nxt   = {LIT_NAME_PAT, never_idx_r, 4'b0000};
          state_nxt      = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = pfx_byte;
          out_last_nxt  = 1'b0;
          out_done_nxt  = 1'b0;
          out_ovf_nxt   = 1'b0;
          int_first_nxt = 1'b0;
          if (pfx_fin) begin
            if (!int_is_val_r) begin
              if (nl_r != '0) begin
                phase_nxt      = PH_NAME;
                bytes_left_nxt = nl_r;
                out_last_nxt   = 1'b1;
                state_nxt      = ST_IDLE;
              end else begin
                // empty name: straight on to the value length
                int_first_nxt  = 1'b1;
                int_is_val_nxt = 1'b1;
                int_lead_nxt   = '0;
              end
            end else begin
              out_last_nxt = 1'b1;
              state_nxt    = ST_IDLE;
              if (vl_r != '0) begin
                phase_nxt      = PH_VALUE;
                bytes_left_nxt = vl_r;
              end else begin
                phase_nxt    = PH_IDLE;
                out_done_nxt = 1'b1;
              end
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // next remainder of the prefix unit: loaded on entry, stepped while emitting
  logic [LEN_BITS-1:0] int_v_load;
  always_comb begin
    int_v_load = int_v_r;
    if (state_r == ST_CHECK) begin
      int_v_load = nl_r;
    end else if (state_r == ST_IDLE) begin
      int_v_load = vl_r;
    end else if (slot) begin
      int_v_load = (pfx_fin && !int_is_val_r) ? vl_r : int_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_r      <= PH_IDLE;
      bytes_left_r <= '0;
      never_idx_r  <= 1'b1;
      out_valid_r  <= 1'b0;
      int_first_r  <= 1'b0;
      int_is_val_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      never_idx_r  <= never_idx_nxt;
      out_valid_r  <= out_valid_nxt;
      int_first_r  <= int_first_nxt;
      int_is_val_r <= int_is_val_nxt;
    end
    nl_r       <= nl_nxt;
    vl_r       <= vl_nxt;
    room_r     <= room_nxt;
    int_v_r    <= int_v_load;
    int_lead_r <= int_lead_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

endmodule

[verif/testbench.sv]
// Self-checking bench for the QPACK literal field line encoder: random and
// directed header beats, a local encoder predictor and an in-order checker.
// Depends on qlf_pkg, the channel interfaces and the encoder top level.
`timescale 1ns / 1ps

module testbench;
  import qlf_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED    = 2'd3;
  localparam int unsigned      NAME_PFX_BITS = 3;
  localparam int unsigned      VAL_PFX_BITS  = 7;
  localparam int unsigned      RAND_ITEMS    = 84;
  localparam int unsigned      N_SETTINGS    = 6;
  localparam int unsigned      SETTLE_CYC    = 24;
  localparam int unsigned      TAIL_CYC      = 40;
  localparam int unsigned      CYCLE_LIMIT   = 600000;
  localparam int unsigned      MAX_ROOM      = (1 << ROOM_W) - 1;
  localparam int unsigned      MAX_LEN       = (1 << LEN_IN_W) - 1;

  typedef enum logic [1:0] {HDR_IDLE, HDR_NAME, HDR_VALUE} hdr_phase_t;

  // one queued stimulus entry: either a request beat or a register write
  typedef struct {
    bit                  is_cfg;
    bit                  cfg_val;
    logic [REQ_W-1:0]    req;
    logic [LEN_IN_W-1:0] nl;
    logic [LEN_IN_W-1:0] vl;
    logic [ROOM_W-1:0]   room;
    logic [BYTE_W-1:0]   data;
    int unsigned         gap;
  } field_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              header_done;
    logic              overflow;
  } enc_beat_t;

  logic clk;
  logic rst_n;

  qlf_in_if  in_ch();
  qlf_out_if out_ch();
  qlf_cfg_if cfg_ch();

  qpack_literal_field_line_encoder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  field_req_t  pending_reqs[$];
  enc_beat_t   due_bytes[$];

  // encoder state as predicted
  logic        ni_bit;
  hdr_phase_t  hdr_phase;
  int unsigned bytes_left;
  int unsigned held_vlen;

  // handshake flags, registered at the rising edge for the falling-edge drivers
  logic        in_took, cfg_took, sink_took;
  int unsigned idle_cycles;
  int unsigned cycles;
  int unsigned errors;
  int unsigned gap_count;
  int unsigned sink_wait;
  int unsigned sink_mode_left;
  bit          sink_calm;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // ---------------------------------------------------------------- prediction

  // bytes a prefix integer takes with the given prefix width
  function automatic int unsigned prefix_bytes(int unsigned v, int unsigned bits);
    int unsigned top;
    int unsigned n;
    top = (1 << bits) - 1;
    if (v < top) return 1;
    v -= top;
    n = 2;
    while (v >= GRP_LIMIT) begin
      v = v >> GRP_BITS;
      n++;
    end
    return n;
  endfunction

  task automatic emit_beat(logic [BYTE_W-1:0] b, logic done, logic ovf);
    enc_beat_t e;
    e.out_byte    = b;
    e.run_last    = 1'b0;
    e.header_done = done;
    e.overflow    = ovf;
    due_bytes.push_back(e);
  endtask

  // prefix all ones, then 7-bit groups LS first with the continuation bit
  task automatic emit_prefix(int unsigned v, int unsigned bits, logic [BYTE_W-1:0] first);
    int unsigned top;
    top = (1 << bits) - 1;
    if (v < top) begin
      emit_beat(first | BYTE_W'(v), 1'b0, 1'b0);
    end else begin
      emit_beat(first | BYTE_W'(top), 1'b0, 1'b0);
      v -= top;
      while (v >= GRP_LIMIT) begin
        emit_beat(BYTE_W'(v & VAL_PFX_MAX) | CONT_BIT, 1'b0, 1'b0);
        v = v >> GRP_BITS;
      end
      emit_beat(BYTE_W'(v), 1'b0, 1'b0);
    end
  endtask

  // value string: H=0 plus 7-bit length prefix; an empty value ends the line
  task automatic open_value(int unsigned vl);
    emit_prefix(vl, VAL_PFX_BITS, 8'h00);
    if (vl > 0) begin
      hdr_phase  = HDR_VALUE;
      bytes_left = vl;
    end else begin
      hdr_phase  = HDR_IDLE;
      bytes_left = 0;
      due_bytes[due_bytes.size()-1].header_done = 1'b1;
    end
    held_vlen = 0;
  endtask

  task automatic encode_item(logic [REQ_W-1:0] req, int unsigned nl, int unsigned vl,
                             int unsigned room, logic [BYTE_W-1:0] b);
    int unsigned n_before;
    int unsigned need;
    n_before = due_bytes.size();
    if (req == REQ_START) begin
      need = prefix_bytes(nl, NAME_PFX_BITS) + nl + prefix_bytes(vl, VAL_PFX_BITS) + vl;
      if (need > room) begin
        // too long: single error beat, the rest of this header is swallowed
        hdr_phase  = HDR_IDLE;
        bytes_left = 0;
        held_vlen  = 0;
        emit_beat('0, 1'b1, 1'b1);
      end else begin
        emit_prefix(nl, NAME_PFX_BITS, {LIT_NAME_PAT, ni_bit, 1'b0, 3'b000});
        if (nl > 0) begin
          hdr_phase  = HDR_NAME;
          bytes_left = nl;
          held_vlen  = vl;
        end else begin
          open_value(vl);
        end
      end
    end else if (req == REQ_NAME && hdr_phase == HDR_NAME) begin
      emit_beat(b, 1'b0, 1'b0);
      bytes_left--;
      if (bytes_left == 0) open_value(held_vlen);
    end else if (req == REQ_VALUE && hdr_phase == HDR_VALUE) begin
      bytes_left--;
      emit_beat(b, bytes_left == 0, 1'b0);
      if (bytes_left == 0) hdr_phase = HDR_IDLE;
    end
    // out-of-sequence bytes and the unused code leave everything alone
    if (due_bytes.size() > n_before) due_bytes[due_bytes.size()-1].run_last = 1'b1;
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic add_req(logic [REQ_W-1:0] req, int unsigned nl, int unsigned vl,
                         int unsigned room, logic [BYTE_W-1:0] data, int unsigned gap);
    field_req_t r;
    r.is_cfg  = 1'b0;
    r.cfg_val = 1'b0;
    r.req     = req;
    r.nl      = LEN_IN_W'(nl);
    r.vl      = LEN_IN_W'(vl);
    r.room    = ROOM_W'(room);
    r.data    = data;
    r.gap     = gap;
    pending_reqs.push_back(r);
  endtask

  task automatic add_cfg(bit val);
    field_req_t r;
    r = '{default: '0};
    r.is_cfg  = 1'b1;
    r.cfg_val = val;
    pending_reqs.push_back(r);
  endtask

  function automatic int unsigned draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic logic [BYTE_W-1:0] rnd_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  initial begin
    int unsigned seg_end;
    int unsigned kind;
    int unsigned nl, vl, room, need, nb;
    bit          calm;

    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.req_type = REQ_START;
    in_ch.name_length  = '0;
    in_ch.value_length = '0;
    in_ch.room      = '0;
    in_ch.data_byte = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.never_indexed = 1'b1;
    out_ch.ready    = 1'b0;

    // directed part
    add_cfg(1'b1);
    add_req(REQ_START, 0, 0, 2, 8'h00, 0);            // both empty, fits exactly
    add_req(REQ_START, 0, 0, 1, 8'h00, 1);            // one byte short
    add_req(REQ_START, 0, 0, 0, 8'h00, 0);            // no room at all
    add_req(REQ_NAME, 0, 0, 0, 8'hFF, 2);             // name byte while idle
    add_req(REQ_VALUE, 0, 0, 0, 8'h00, 0);            // value byte while idle
    add_req(REQ_UNUSED, 0, 0, 0, 8'h3C, 0);           // unused request code
    add_req(REQ_START, 2, 1, 5, 8'h00, 0);            // exact fit with bytes
    add_req(REQ_NAME, 0, 0, 0, 8'h00, 0);
    add_req(REQ_VALUE, 0, 0, 0, 8'hEE, 0);            // value byte in name phase
    add_req(REQ_NAME, 0, 0, 0, 8'hFF, 3);
    add_req(REQ_VALUE, 0, 0, 0, 8'hA5, 0);
    add_req(REQ_START, 7, 127, MAX_ROOM, 8'h00, 0);   // both prefixes just overflow
    add_req(REQ_START, MAX_LEN, MAX_LEN, MAX_ROOM, 8'h00, 0); // restart, longest prefix
    add_req(REQ_NAME, 0, 0, 0, 8'h81, 0);
    add_req(REQ_START, 1, MAX_LEN, MAX_ROOM, 8'h00, 5); // restart mid name
    add_req(REQ_NAME, 0, 0, 0, 8'h7E, 0);             // byte plus 4-byte value prefix
    add_req(REQ_VALUE, 0, 0, 0, 8'h01, 0);
    add_req(REQ_START, 6, 126, 1, 8'h00, 0);          // restart into overflow
    add_req(REQ_NAME, 0, 0, 0, 8'h42, 0);             // absorbed
    add_req(REQ_START, 1, 0, 3, 8'h00, 16);           // empty value after name
    add_req(REQ_NAME, 0, 0, 0, 8'h5A, 0);

    // random part, split into register settings
    for (int ph = 0; ph < N_SETTINGS; ph++) begin
      if (ph == 0)      add_cfg(1'b0);
      else if (ph == 1) add_cfg(1'b1);
      else              add_cfg(bit'($urandom_range(0, 1)));
      seg_end = pending_reqs.size() + RAND_ITEMS / N_SETTINGS;
      while (pending_reqs.size() < seg_end) begin
        calm = ($urandom_range(0, 3) == 0);
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
          // well-formed line, mostly short, sometimes a longer name
          if (kind < 60) begin
            nl = $urandom_range(0, 6);
            vl = $urandom_range(0, 6);
          end else begin
            nl = $urandom_range(5, 12);
            vl = $urandom_range(0, 40);
          end
          need = prefix_bytes(nl, NAME_PFX_BITS) + nl + prefix_bytes(vl, VAL_PFX_BITS) + vl;
          room = need + $urandom_range(0, 3);
          add_req(REQ_START, nl, vl, room, rnd_byte(), draw_gap(calm));
          for (int i = 0; i < nl + vl; i++) begin
            if ($urandom_range(0, 9) == 0)
              add_req(i < nl ? REQ_VALUE : REQ_NAME, 0, 0, 0, rnd_byte(), draw_gap(calm));
            add_req(i < nl ? REQ_NAME : REQ_VALUE, $urandom_range(0, MAX_LEN),
                    $urandom_range(0, MAX_LEN), $urandom_range(0, MAX_ROOM), rnd_byte(),
                    draw_gap(calm));
          end
        end else if (kind < 85) begin
          // too long for the room; its bytes are then swallowed
          nl = $urandom_range(0, 6);
          vl = $urandom_range(0, 6);
          need = prefix_bytes(nl, NAME_PFX_BITS) + nl + prefix_bytes(vl, VAL_PFX_BITS) + vl;
          room = $urandom_range(0, need - 1);
          add_req(REQ_START, nl, vl, room, rnd_byte(), draw_gap(calm));
          for (int i = 0; i < nl + vl; i++)
            add_req(i < nl ? REQ_NAME : REQ_VALUE, 0, 0, 0, rnd_byte(), draw_gap(calm));
        end else begin
          // cut-off header with wide lengths, ended by the next start
          nl = $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(0, MAX_LEN);
          vl = $urandom_range(0, MAX_LEN);
          room = $urandom_range(0, MAX_ROOM);
          add_req(REQ_START, nl, vl, room, rnd_byte(), draw_gap(calm));
          nb = (nl < 3) ? nl : 3;
          for (int i = 0; i < nb; i++) begin
            add_req(REQ_NAME, 0, 0, 0, rnd_byte(), draw_gap(calm));
          end
          if (nl <= 3) begin
            nb = $urandom_range(0, 2);
            for (int i = 0; i < nb; i++) begin
              add_req(REQ_VALUE, 0, 0, 0, rnd_byte(), draw_gap(calm));
            end
          end
        end
        if ($urandom_range(0, 7) == 0)
          add_req(REQ_W'($urandom_range(REQ_NAME, REQ_UNUSED)), 0, 0, 0, rnd_byte(),
                  draw_gap(calm));
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // drain: queue empty, nothing due, then a quiet tail
    @(posedge clk);
    while (!(pending_reqs.size() == 0 && !in_ch.valid && !cfg_ch.valid &&
             due_bytes.size() == 0 && idle_cycles >= TAIL_CYC))
      @(posedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------- drivers

  // request and register channels; a register write waits for a quiet block
  always @(negedge clk) begin : req_driver
    logic nv;
    logic ncv;
    if (rst_n) begin
      nv  = in_ch.valid;
      ncv = cfg_ch.valid;
      if (in_took) nv = 1'b0;
      if (cfg_took) begin
        ncv = 1'b0;
        void'(pending_reqs.pop_front());
      end
      if (!nv && !ncv && pending_reqs.size() > 0) begin
        if (pending_reqs[0].is_cfg) begin
          if (idle_cycles >= SETTLE_CYC && !cfg_took) begin
            ncv = 1'b1;
            cfg_ch.never_indexed <= pending_reqs[0].cfg_val;
          end
        end else if (gap_count < pending_reqs[0].gap) begin
          gap_count++;
        end else begin
          in_ch.req_type     <= pending_reqs[0].req;
          in_ch.name_length  <= pending_reqs[0].nl;
          in_ch.value_length <= pending_reqs[0].vl;
          in_ch.room         <= pending_reqs[0].room;
          in_ch.data_byte    <= pending_reqs[0].data;
          nv = 1'b1;
          gap_count = 0;
          void'(pending_reqs.pop_front());
        end
      end
      in_ch.valid  <= nv;
      cfg_ch.valid <= ncv;
    end
  end

  // result sink: a fresh random stall after every beat in busy stretches, none in calm ones
  always @(negedge clk) begin : sink_driver
    if (rst_n) begin
      if (sink_took) begin
        if (sink_mode_left == 0) begin
          sink_calm      = ($urandom_range(0, 2) == 0);
          sink_mode_left = $urandom_range(8, 40);
        end
        sink_mode_left--;
        sink_wait = sink_calm ? 0 : $urandom_range(0, 16);
      end
      if (sink_wait > 0) begin
        out_ch.ready <= 1'b0;
        sink_wait--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  initial begin
    ni_bit         = 1'b1;
    hdr_phase      = HDR_IDLE;
    bytes_left     = 0;
    held_vlen      = 0;
    in_took        = 1'b0;
    cfg_took       = 1'b0;
    sink_took      = 1'b0;
    idle_cycles    = 0;
    cycles         = 0;
    errors         = 0;
    gap_count      = 0;
    sink_wait      = 0;
    sink_mode_left = 0;
    sink_calm      = 1'b0;
  end

  always @(posedge clk) begin : beat_monitor
    enc_beat_t want;
    enc_beat_t got;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else if (rst_n) begin
      in_took   <= in_ch.valid && in_ch.ready;
      cfg_took  <= cfg_ch.valid && cfg_ch.ready;
      sink_took <= out_ch.valid && out_ch.ready;

      // register only ever written with the block quiet
      if (cfg_ch.valid && cfg_ch.ready) ni_bit = cfg_ch.never_indexed;

      if (in_ch.valid && in_ch.ready)
        encode_item(in_ch.req_type, in_ch.name_length, in_ch.value_length, in_ch.room,
                    in_ch.data_byte);

      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.out_byte, out_ch.run_last, out_ch.header_done, out_ch.overflow};
        if (due_bytes.size() == 0) begin
          errors++;
          $display("%0t: beat with nothing due, got byte %02h last %b done %b ovf %b",
                   $time, got.out_byte, got.run_last, got.header_done, got.overflow);
        end else begin
          want = due_bytes.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: expected byte %02h last %b done %b ovf %b, got %02h %b %b %b",
                     $time, want.out_byte, want.run_last, want.header_done, want.overflow,
                     got.out_byte, got.run_last, got.header_done, got.overflow);
          end
        end
      end

      if (due_bytes.size() == 0 && !in_ch.valid && !out_ch.valid)
        idle_cycles++;
      else
        idle_cycles = 0;
    end
  end

endmodule
